>>> sv/mrfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
package mrfc_pkg;

    localparam int          DEF_MAX_FRAME = 256;
    localparam int          MIN_FRAME     = 8;
    localparam int          PAYLOAD_OFS   = 6;

    localparam logic [15:0] CRC_START     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  CRC_WILDCARD  = 8'hAA;
    localparam logic [7:0]  SLAVE_RESET   = 8'h01;
    localparam logic [7:0]  BROADCAST     = 8'h00;

    typedef enum logic
    {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_OK          = 3'd0,
        ST_WRONG_SLAVE = 3'd1,
        ST_CRC_BAD     = 3'd2,
        ST_TOO_SHORT   = 3'd3,
        ST_TOO_LONG    = 3'd4
    } status_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        status_t     status;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] register_count;
        logic [7:0]  payload_length;
    } result_t;

    // One byte through the reflected CRC-16, eight shift steps unrolled.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/mrfc_parser.sv
// Frame state: byte counter, CRC, two-byte delay, header capture, result building.
module mrfc_parser #(
    parameter int MAX_FRAME = mrfc_pkg::DEF_MAX_FRAME
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_frame,
    input  logic [7:0]        slave_address,
    output logic              res_valid,
    output mrfc_pkg::result_t res
);
    import mrfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 2);

    localparam logic [CNT_W-1:0] CNT_SAT      = CNT_W'(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_FWD_LO   = CNT_W'(PAYLOAD_OFS + 1);
    localparam logic [CNT_W-1:0] CNT_FWD_HI   = CNT_W'(MAX_FRAME - 2);
    localparam logic [CNT_W-1:0] CNT_MIN_LAST = CNT_W'(MIN_FRAME - 1);
    localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] OFS_SLAVE    = CNT_W'(0);
    localparam logic [CNT_W-1:0] OFS_FUNC     = CNT_W'(1);
    localparam logic [CNT_W-1:0] OFS_ADDR_HI  = CNT_W'(2);
    localparam logic [CNT_W-1:0] OFS_ADDR_LO  = CNT_W'(3);
    localparam logic [CNT_W-1:0] OFS_CNT_HI   = CNT_W'(4);
    localparam logic [CNT_W-1:0] OFS_CNT_LO   = CNT_W'(5);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       d0_reg, d0_next;
    logic [7:0]       d1_reg, d1_next;
    logic [7:0]       slave_reg, slave_next;
    logic [7:0]       func_reg, func_next;
    logic [15:0]      addr_reg, addr_next;
    logic [15:0]      count_reg, count_next;

    logic [15:0]      crc_upd;
    logic [7:0]       slave_upd, func_upd;
    logic [15:0]      addr_upd, count_upd;
    logic [7:0]       ofs_low;
    logic             crc_lo_ok, crc_hi_ok;
    status_t          status;

    always_comb
    begin
        // the byte leaving the delay enters the CRC once two bytes are held
        crc_upd   = (cnt_reg >= OFS_ADDR_HI) ? crc_feed(crc_reg, d1_reg) : crc_reg;

        slave_upd = (cnt_reg == OFS_SLAVE)   ? data_byte : slave_reg;
        func_upd  = (cnt_reg == OFS_FUNC)    ? data_byte : func_reg;
        addr_upd  = addr_reg;
        count_upd = count_reg;
        if (cnt_reg == OFS_ADDR_HI)
        begin
            addr_upd = {data_byte, 8'h00};
        end
        if (cnt_reg == OFS_ADDR_LO)
        begin
            addr_upd = {addr_reg[15:8], data_byte};
        end
        if (cnt_reg == OFS_CNT_HI)
        begin
            count_upd = {data_byte, 8'h00};
        end
        if (cnt_reg == OFS_CNT_LO)
        begin
            count_upd = {count_reg[15:8], data_byte};
        end

        ofs_low   = 8'(cnt_reg - CNT_FWD_LO);

        // received CRC: low byte sits in the delay, high byte is this beat
        crc_lo_ok = (d0_reg == crc_upd[7:0])  || (d0_reg == CRC_WILDCARD);
        crc_hi_ok = (data_byte == crc_upd[15:8]) || (data_byte == CRC_WILDCARD);

        if (cnt_reg < CNT_MIN_LAST)
        begin
            status = ST_TOO_SHORT;
        end
        else if (cnt_reg >= CNT_MAX)
        begin
            status = ST_TOO_LONG;
        end
        else if (slave_upd != slave_address && slave_upd != BROADCAST)
        begin
            status = ST_WRONG_SLAVE;
        end
        else if (!crc_lo_ok || !crc_hi_ok)
        begin
            status = ST_CRC_BAD;
        end
        else
        begin
            status = ST_OK;
        end

        res = '0;
        if (end_of_frame)
        begin
            res_valid            = 1'b1;
            res.kind             = KIND_VERDICT;
            res.status           = status;
            res.function_code    = func_upd;
            res.register_address = addr_upd;
            res.register_count   = count_upd;
            res.payload_length   = (status == ST_TOO_SHORT || status == ST_TOO_LONG)
                                   ? 8'h00 : ofs_low;
        end
        else
        begin
            res_valid         = (cnt_reg >= CNT_FWD_LO) && (cnt_reg <= CNT_FWD_HI);
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = d0_reg;
            res.payload_index = ofs_low;
        end

        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        slave_next = slave_reg;
        func_next  = func_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                cnt_next   = '0;
                crc_next   = CRC_START;
                d0_next    = '0;
                d1_next    = '0;
                slave_next = '0;
                func_next  = '0;
                addr_next  = '0;
                count_next = '0;
            end
            else
            begin
                cnt_next   = (cnt_reg < CNT_SAT) ? cnt_reg + CNT_W'(1) : cnt_reg;
                crc_next   = crc_upd;
                d0_next    = data_byte;
                d1_next    = d0_reg;
                slave_next = slave_upd;
                func_next  = func_upd;
                addr_next  = addr_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            crc_reg   <= CRC_START;
            d0_reg    <= '0;
            d1_reg    <= '0;
            slave_reg <= '0;
            func_reg  <= '0;
            addr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            slave_reg <= slave_next;
            func_reg  <= func_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/mrfc_out_buf.sv
// Output register with a one-entry skid stage; input stall comes from a flop.
module mrfc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrfc_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output mrfc_pkg::result_t out_data
);
    import mrfc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    taken;

    always_comb
    begin
        taken           = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg && !taken;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            // no push is possible while the skid holds a beat
            if (taken)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || taken)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/modbus_rtu_frame_checker.sv
// Top level of the Modbus RTU frame checker: config register, frame parser, output buffer.
//
// Input channel: one frame byte per beat (data_byte), end_of_frame high on the
// last byte. Accepted when in_valid is high and in_stall is low.
// Output channel: one result beat per forwarded payload byte (result_kind 0) and
// one verdict beat at end of frame (result_kind 1, with status, header fields and
// payload length). Taken when out_valid is high and out_stall is low.
// Throughput: one byte per cycle while in_stall is low. The CRC-16 byte update is eight
// unrolled shift steps on the byte leaving the two-byte delay, in the same cycle a byte
// is accepted. Each result is registered into the output register or the skid entry.
// A payload byte is forwarded with the next byte, since the last two bytes of a frame
// are held back as the received CRC.
// Stall: the output register plus a one-entry skid keep accepting while one result
// waits; in_stall rises only when both are occupied and is driven from a flop.
// Reset: frame state clears, slave_address returns to 1, both buffers empty.
// slave_address is written with cfg_wr_en; write it only between frames.
module modbus_rtu_frame_checker #(
    parameter int MAX_FRAME = mrfc_pkg::DEF_MAX_FRAME
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_frame,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [2:0]  frame_status,
    output logic [7:0]  function_code,
    output logic [15:0] register_address,
    output logic [15:0] register_count,
    output logic [7:0]  payload_length
);
    import mrfc_pkg::*;

    logic [7:0] slave_addr_reg;
    logic       accept;
    logic       res_valid;
    result_t    res;
    result_t    out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            slave_addr_reg <= cfg_wr_data;
        end
    end

    assign accept = in_valid && !in_stall;

    mrfc_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_frame  (end_of_frame),
        .slave_address (slave_addr_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // only beats that produce a result enter the buffer
    mrfc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign result_kind      = out_data.kind;
    assign payload_byte     = out_data.payload_byte;
    assign payload_index    = out_data.payload_index;
    assign frame_status     = out_data.status;
    assign function_code    = out_data.function_code;
    assign register_address = out_data.register_address;
    assign register_count   = out_data.register_count;
    assign payload_length   = out_data.payload_length;

endmodule

>>> tb/sv/mrfc_result_checker.sv
// Result checker for the Modbus RTU frame checker: tracks input beats, predicts and scores output beats.
`timescale 1ns / 1ps

module mrfc_result_checker #(
    parameter int MAX_FRAME = mrfc_pkg::DEF_MAX_FRAME
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_frame,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        result_kind,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  payload_index,
    input  logic [2:0]  frame_status,
    input  logic [7:0]  function_code,
    input  logic [15:0] register_address,
    input  logic [15:0] register_count,
    input  logic [7:0]  payload_length,

    output int          mismatch_count,
    output int          open_results
);

    import mrfc_pkg::*;

    // Shadow of the block's register and frame state
    logic [7:0]  own_address;
    logic [15:0] crc_acc;
    logic [7:0]  newest_byte;
    logic [7:0]  older_byte;
    int unsigned frame_bytes;
    logic [7:0]  hdr_slave;
    logic [7:0]  hdr_function;
    logic [15:0] hdr_register;
    logic [15:0] hdr_count;

    result_t     expected_q[$];
    result_t     seen_beat;
    result_t     want_beat;
    result_t     next_beat;
    int          fail_total;

    // Bit-serial form of the reflected CRC-16 update
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ octet[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void clear_frame();
        crc_acc      = CRC_START;
        newest_byte  = '0;
        older_byte   = '0;
        frame_bytes  = 0;
        hdr_slave    = '0;
        hdr_function = '0;
        hdr_register = '0;
        hdr_count    = '0;
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("kind=%0d byte=%h idx=%0d st=%0d fc=%h ra=%h rc=%h len=%0d",
                         r.kind, r.payload_byte, r.payload_index, r.status,
                         r.function_code, r.register_address, r.register_count,
                         r.payload_length);
    endfunction

    // One input beat through the frame parser; returns 1 when it yields a result beat
    function automatic bit advance_frame(input logic [7:0] b, input logic eof,
                                         output result_t r);
        int unsigned n;
        int unsigned len;
        bit          lo_ok;
        bit          hi_ok;
        n = frame_bytes;
        r = '0;

        // the byte leaving the two-deep hold enters the CRC
        if (n >= 2)
            crc_acc = crc16_step(crc_acc, older_byte);

        case (n)
            0: hdr_slave          = b;
            1: hdr_function       = b;
            2: hdr_register[15:8] = b;
            3: hdr_register[7:0]  = b;
            4: hdr_count[15:8]    = b;
            5: hdr_count[7:0]     = b;
            default: ;
        endcase

        if (!eof)
        begin
            advance_frame = 1'b0;
            if (n >= 7 && n <= MAX_FRAME - 2)
            begin
                r.kind          = KIND_PAYLOAD;
                r.payload_byte  = newest_byte;
                r.payload_index = 8'(n - 7);
                advance_frame   = 1'b1;
            end
            older_byte  = newest_byte;
            newest_byte = b;
            if (frame_bytes < MAX_FRAME + 1)
                frame_bytes++;
            return advance_frame;
        end

        len   = n + 1;
        lo_ok = (newest_byte == crc_acc[7:0])  || (newest_byte == CRC_WILDCARD);
        hi_ok = (b           == crc_acc[15:8]) || (b           == CRC_WILDCARD);

        r.kind = KIND_VERDICT;
        if (len < MIN_FRAME)
            r.status = ST_TOO_SHORT;
        else if (len > MAX_FRAME)
            r.status = ST_TOO_LONG;
        else
        begin
            r.payload_length = 8'(len - MIN_FRAME);
            if (hdr_slave != own_address && hdr_slave != BROADCAST)
                r.status = ST_WRONG_SLAVE;
            else if (!lo_ok || !hi_ok)
                r.status = ST_CRC_BAD;
            else
                r.status = ST_OK;
        end
        r.function_code    = hdr_function;
        r.register_address = hdr_register;
        r.register_count   = hdr_count;

        clear_frame();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address = SLAVE_RESET;
            clear_frame();
            expected_q.delete();
            fail_total = 0;
            mismatch_count <= 0;
            open_results   <= 0;
        end
        else
        begin
            // output side first: a beat taken now stems from an earlier input beat
            if (out_valid && !out_stall)
            begin
                seen_beat = result_t'({result_kind, payload_byte, payload_index, frame_status,
                                       function_code, register_address, register_count,
                                       payload_length});
                if (expected_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result beat with nothing expected: %s",
                                 $realtime, describe(seen_beat));
                end
                else
                begin
                    want_beat = expected_q.pop_front();
                    if (seen_beat !== want_beat)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("%0t: result beat mismatch", $realtime);
                            $display("  expected %s", describe(want_beat));
                            $display("  actual   %s", describe(seen_beat));
                        end
                    end
                end
            end

            if (cfg_wr_en)
                own_address = cfg_wr_data;

            if (in_valid && !in_stall)
                if (advance_frame(data_byte, end_of_frame, next_beat))
                    expected_q.push_back(next_beat);

            mismatch_count <= fail_total;
            open_results   <= expected_q.size();
        end
    end

endmodule

>>> tb/sv/modbus_rtu_frame_checker_tb.sv
// Testbench top for the Modbus RTU frame checker: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module modbus_rtu_frame_checker_tb;

    import mrfc_pkg::*;

    localparam int MAX_FRAME   = DEF_MAX_FRAME;
    // input beats per random phase; each phase runs under one slave address
    localparam int PHASE_BEATS = 150;

    // How the two trailing CRC bytes of a generated frame are formed
    typedef enum int
    {
        CRC_GOOD,
        CRC_WILD_LO,
        CRC_WILD_HI,
        CRC_WILD_BOTH,
        CRC_BAD_LO,
        CRC_BAD_HI
    } crc_fault_t;

    // Receiver back-pressure patterns
    typedef enum int
    {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_pattern_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [7:0]  cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte    = '0;
    logic        end_of_frame = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  frame_status;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_count;
    logic [7:0]  payload_length;

    int             mismatch_count;
    int             open_results;

    logic [7:0]     frame_q[$];          // bytes of the frame being sent
    logic [7:0]     cur_slave  = SLAVE_RESET;
    int             beats_sent = 0;
    int             burst_left = 0;
    stall_pattern_t stall_mode = STALL_NONE;
    int             stall_hold = 0;
    int             stall_tick = 0;

    always #10 clk = ~clk;

    modbus_rtu_frame_checker #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .end_of_frame     (end_of_frame),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .payload_byte     (payload_byte),
        .payload_index    (payload_index),
        .frame_status     (frame_status),
        .function_code    (function_code),
        .register_address (register_address),
        .register_count   (register_count),
        .payload_length   (payload_length)
    );

    mrfc_result_checker #(
        .MAX_FRAME (MAX_FRAME)
    ) u_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .end_of_frame     (end_of_frame),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .payload_byte     (payload_byte),
        .payload_index    (payload_index),
        .frame_status     (frame_status),
        .function_code    (function_code),
        .register_address (register_address),
        .register_count   (register_count),
        .payload_length   (payload_length),
        .mismatch_count   (mismatch_count),
        .open_results     (open_results)
    );

    // ------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------

    // CRC-16 over the first 'upto' bytes of the current frame
    function automatic logic [15:0] frame_crc(input int upto);
        logic [15:0] acc;
        acc = CRC_START;
        for (int i = 0; i < upto; i++)
        begin
            acc = acc ^ {8'h00, frame_q[i]};
            repeat (8)
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // Random content; byte 0 is the slave address
    function automatic void fill_frame(input int len, input logic [7:0] slave);
        logic [7:0] octet;
        frame_q.delete();
        for (int i = 0; i < len; i++)
        begin
            octet = 8'($urandom_range(0, 255));
            frame_q.push_back(octet);
        end
        frame_q[0] = slave;
    endfunction

    // Overwrite the last two bytes with the CRC (low byte first), then apply the fault.
    // Short frames of two bytes or more get a CRC too; the block must still call them too short.
    function automatic void seal_frame(input crc_fault_t fault);
        logic [15:0] crc;
        int          n;
        n = frame_q.size();
        if (n < 2)
            return;
        crc          = frame_crc(n - 2);
        frame_q[n-2] = crc[7:0];
        frame_q[n-1] = crc[15:8];
        case (fault)
            CRC_WILD_LO:   frame_q[n-2] = CRC_WILDCARD;
            CRC_WILD_HI:   frame_q[n-1] = CRC_WILDCARD;
            CRC_WILD_BOTH:
            begin
                frame_q[n-2] = CRC_WILDCARD;
                frame_q[n-1] = CRC_WILDCARD;
            end
            CRC_BAD_LO:    frame_q[n-2] = frame_q[n-2] ^ (8'h01 << $urandom_range(0, 7));
            CRC_BAD_HI:    frame_q[n-1] = frame_q[n-1] ^ (8'h01 << $urandom_range(0, 7));
            default: ;
        endcase
    endfunction

    // Mostly ordinary frames; a few too short and a rare one near or past the maximum
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 49);
        if (r < 3)
            return $urandom_range(1, MIN_FRAME - 1);
        if (r == 3)
            return $urandom_range(MAX_FRAME - 6, MAX_FRAME + 44);
        return $urandom_range(MIN_FRAME, 30);
    endfunction

    // Own address most of the time, then broadcast, then anything
    function automatic logic [7:0] pick_slave();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return cur_slave;
        if (r < 17)
            return BROADCAST;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic crc_fault_t pick_fault();
        int r;
        r = $urandom_range(0, 17);
        if (r < 12)
            return CRC_GOOD;
        return crc_fault_t'(r - 12);
    endfunction

    // ------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------

    // Sends one beat. Bursts of random length with random gaps between them;
    // now and then a long burst with no gap at all. valid is only lowered when
    // a gap really follows, so it never drops and rises in one time step.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(64, 200);
            end
            else
            begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 12);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_frame <= eof;
        // in_stall is a flop output, so this reads its value from before the edge
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        beats_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Hold the sender until every expected result beat has arrived. The first
    // edge lets the checker count the beat just accepted. Every frame ends in a
    // verdict, so nothing is in flight afterwards; the task then idles anyway.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    // Only called between frames with the block drained
    task automatic write_slave(input logic [7:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_slave    = v;
    endtask

    // ------------------------------------------------------------------
    // Receiver back-pressure: its own pattern, redrawn when its hold counter runs out
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode = stall_pattern_t'($urandom_range(0, 3));
            stall_hold = $urandom_range(32, 200);
        end
        else
            stall_hold--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 9) < 4);
            STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
            default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] settings [6];
        int         phase_start;

        // broadcast and all-ones extremes, the wildcard value as an address,
        // one random address, and back to the reset value
        settings[0] = BROADCAST;
        settings[1] = 8'hFF;
        settings[2] = SLAVE_RESET;
        settings[3] = 8'($urandom_range(0, 255));
        settings[4] = CRC_WILDCARD;
        settings[5] = SLAVE_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames under the reset address.
        // Minimum length, own address, header fields all ones, good CRC.
        fill_frame(MIN_FRAME, SLAVE_RESET);
        for (int i = 1; i < PAYLOAD_OFS; i++)
            frame_q[i] = 8'hFF;
        seal_frame(CRC_GOOD);
        send_frame();

        // Minimum length, broadcast, header fields all zero, both CRC bytes wildcard.
        fill_frame(MIN_FRAME, BROADCAST);
        for (int i = 1; i < PAYLOAD_OFS; i++)
            frame_q[i] = 8'h00;
        seal_frame(CRC_WILD_BOTH);
        send_frame();

        // A lone byte carrying the end mark: too short, header reported as zero.
        fill_frame(1, 8'hFF);
        send_frame();

        // One payload byte forwarded, then a bad high CRC byte.
        fill_frame(MIN_FRAME + 1, SLAVE_RESET);
        seal_frame(CRC_BAD_HI);
        send_frame();

        // Random phases, one slave address each. Draining before each write
        // also makes the sender wait until every result beat has come.
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            write_slave(settings[p]);
            phase_start = beats_sent;

            if (p == 2)
            begin
                // largest legal frame (payload index reaches 247), then one
                // long enough to saturate the byte counter
                fill_frame(MAX_FRAME, cur_slave);
                seal_frame(CRC_GOOD);
                send_frame();
                fill_frame(MAX_FRAME + 14, cur_slave);
                seal_frame(CRC_GOOD);
                send_frame();
            end

            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                fill_frame(pick_length(), pick_slave());
                seal_frame(pick_fault());
                send_frame();
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (12) @(posedge clk);

        if (mismatch_count == 0 && open_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #(10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/mrfc_pkg.sv
sv/mrfc_parser.sv
sv/mrfc_out_buf.sv
sv/modbus_rtu_frame_checker.sv
tb/sv/mrfc_result_checker.sv
tb/sv/modbus_rtu_frame_checker_tb.sv
